/* rtl/matrix_range_add_set_query_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the matrix range add / set / query block
// Shared concurrent assertion forms, disabled while the active-low reset is low.
// ---------------------------------------------------------------------------
`ifndef MATRIX_RANGE_ADD_SET_QUERY_DEFINES_SVH
`define MATRIX_RANGE_ADD_SET_QUERY_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define MRAS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define MRAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/mras_pkg.sv */
// ---------------------------------------------------------------------------
// mras_pkg
// Widths, codes and defaults shared by the matrix range add / set / query block.
// ---------------------------------------------------------------------------
`default_nettype none

package mras_pkg;

    // Field widths
    localparam int OP_W       = 2;
    localparam int ROW_W      = 6;
    localparam int COL_W      = 11;
    localparam int VAL_W      = 31;
    localparam int SUM_W      = 46;
    localparam int ELEM_W     = 64;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    // Parameter defaults
    localparam int MAX_ROWS_DEF = 32;
    localparam int MAX_COLS_DEF = 1024;

    // Register values after reset (before saturation to the build limits)
    localparam int RESET_ROWS = 32;
    localparam int RESET_COLS = 1024;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_ASSIGN = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 1'b1;

endpackage

`default_nettype wire

/* rtl/mras_if.sv */
// ---------------------------------------------------------------------------
// mras channel interfaces
// Request, result and configuration channels with valid / ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

// Request channel: one rectangle operation
interface mras_req_if;
    logic                           valid;
    logic                           ready;
    logic [mras_pkg::OP_W-1:0]      opcode;
    logic [mras_pkg::ROW_W-1:0]     row_lo;
    logic [mras_pkg::ROW_W-1:0]     row_hi;
    logic [mras_pkg::COL_W-1:0]     col_lo;
    logic [mras_pkg::COL_W-1:0]     col_hi;
    logic [mras_pkg::VAL_W-1:0]     operand_value;

    modport source (output valid, opcode, row_lo, row_hi, col_lo, col_hi, operand_value,
                    input ready);
    modport sink   (input valid, opcode, row_lo, row_hi, col_lo, col_hi, operand_value,
                    output ready);
endinterface

// Result channel: query answer
interface mras_res_if;
    logic                           valid;
    logic                           ready;
    logic [mras_pkg::SUM_W-1:0]     total_sum;
    logic [mras_pkg::VAL_W-1:0]     min_value;
    logic [mras_pkg::VAL_W-1:0]     max_value;

    modport source (output valid, total_sum, min_value, max_value, input ready);
    modport sink   (input valid, total_sum, min_value, max_value, output ready);
endinterface

// Configuration write channel
interface mras_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mras_pkg::CFG_IDX_W-1:0]     index;
    logic [mras_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/mras_ram.sv */
// ---------------------------------------------------------------------------
// mras_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module mras_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/matrix_range_add_set_query.sv */
// Each request walks its clipped rectangle row by row until the block is idle (add,
// assign) or the result is valid (query); an empty query answers without a walk.
// Throughput: one element per cycle through the element memory's read-modify-write
// loop; one request at a time, the next accepted once the block is idle again.
// Reset and every configuration write start a clearing pass over the whole
// element memory; no request is taken then.
// ---------------------------------------------------------------------------
// matrix_range_add_set_query
// Matrix store with rectangle add, rectangle assign and sum/min/max query,
// walking the element memory one entry per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

`include "matrix_range_add_set_query_defines.svh"

module matrix_range_add_set_query #(
    parameter int MAX_ROWS = mras_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = mras_pkg::MAX_COLS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mras_req_if.sink    i_req,
    mras_res_if.source  o_res,
    mras_cfg_if.sink    i_cfg
);

    localparam int ROW_W  = mras_pkg::ROW_W;
    localparam int COL_W  = mras_pkg::COL_W;
    localparam int VAL_W  = mras_pkg::VAL_W;
    localparam int SUM_W  = mras_pkg::SUM_W;
    localparam int ELEM_W = mras_pkg::ELEM_W;

    localparam int RB    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CB    = $clog2(MAX_COLS);
    localparam int AW    = RB + CB;
    localparam int DEPTH = 1 << AW;

    // Saturation limits as seen through the register field widths
    localparam logic [ROW_W-1:0] ROWS_CAP =
        (MAX_ROWS > (1 << ROW_W) - 1) ? {ROW_W{1'b1}} : ROW_W'(MAX_ROWS);
    localparam logic [COL_W-1:0] COLS_CAP =
        (MAX_COLS > (1 << COL_W) - 1) ? {COL_W{1'b1}} : COL_W'(MAX_COLS);
    localparam logic [ROW_W-1:0] ROWS_RST =
        (mras_pkg::RESET_ROWS > MAX_ROWS) ? ROW_W'(MAX_ROWS) : ROW_W'(mras_pkg::RESET_ROWS);
    localparam logic [COL_W-1:0] COLS_RST =
        (mras_pkg::RESET_COLS > MAX_COLS) ? COL_W'(MAX_COLS) : COL_W'(mras_pkg::RESET_COLS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_LOAD,
        S_OUT
    } t_state;

    t_state                     r_state;
    logic [AW-1:0]              r_sweep;
    logic [ROW_W-1:0]           r_rows;
    logic [COL_W-1:0]           r_cols;
    logic [mras_pkg::OP_W-1:0]  r_op;
    logic [VAL_W-1:0]           r_val;
    logic [ROW_W-1:0]           r_rhi;
    logic [COL_W-1:0]           r_clo;
    logic [COL_W-1:0]           r_chi;
    logic [ROW_W-1:0]           r_row;
    logic [COL_W-1:0]           r_col;
    logic                       r_p_valid;
    logic [AW-1:0]              r_p_addr;
    logic [SUM_W-1:0]           r_sum;
    logic [ELEM_W-1:0]          r_min;
    logic [ELEM_W-1:0]          r_max;
    logic                       r_res_valid;
    logic [SUM_W-1:0]           r_res_sum;
    logic [VAL_W-1:0]           r_res_min;
    logic [VAL_W-1:0]           r_res_max;

    logic [ROW_W-1:0]   w_rlo;
    logic [ROW_W-1:0]   w_rhi;
    logic [COL_W-1:0]   w_clo;
    logic [COL_W-1:0]   w_chi;
    logic               w_empty;
    logic               w_req_acc;
    logic [AW-1:0]      w_raddr;
    logic [ELEM_W-1:0]  w_rdata;
    logic               w_we;
    logic [AW-1:0]      w_waddr;
    logic [ELEM_W-1:0]  w_wdata;
    logic [ELEM_W-1:0]  n_elem;
    logic [ROW_W-1:0]   n_rows;
    logic [COL_W-1:0]   n_cols;

    // Handshakes
    assign i_req.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign w_req_acc   = i_req.valid && i_req.ready;

    assign o_res.valid     = r_res_valid;
    assign o_res.total_sum = r_res_sum;
    assign o_res.min_value = r_res_min;
    assign o_res.max_value = r_res_max;

    // Clip the rectangle to the matrix in use
    always_comb begin
        w_rlo   = (i_req.row_lo == '0) ? ROW_W'(1) : i_req.row_lo;
        w_rhi   = (i_req.row_hi > r_rows) ? r_rows : i_req.row_hi;
        w_clo   = (i_req.col_lo == '0) ? COL_W'(1) : i_req.col_lo;
        w_chi   = (i_req.col_hi > r_cols) ? r_cols : i_req.col_hi;
        w_empty = (w_rlo > w_rhi) || (w_clo > w_chi);
    end

    // Saturated register values
    always_comb begin
        n_rows = i_cfg.data[ROW_W-1:0];
        if (n_rows == '0) begin
            n_rows = ROW_W'(1);
        end
        if (n_rows > ROWS_CAP) begin
            n_rows = ROWS_CAP;
        end
        n_cols = i_cfg.data[COL_W-1:0];
        if (n_cols == '0) begin
            n_cols = COL_W'(1);
        end
        if (n_cols > COLS_CAP) begin
            n_cols = COLS_CAP;
        end
    end

    // Element address of the walk position, read every cycle
    assign w_raddr = {RB'(r_row - ROW_W'(1)), CB'(r_col - COL_W'(1))};

    // Modified element and write-back port
    always_comb begin
        if (r_op == mras_pkg::OP_ASSIGN) begin
            n_elem = ELEM_W'(r_val);
        end else begin
            n_elem = w_rdata + ELEM_W'(r_val);
        end
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_sweep;
            w_wdata = '0;
        end else begin
            w_we    = r_p_valid && (r_op != mras_pkg::OP_QUERY);
            w_waddr = r_p_addr;
            w_wdata = n_elem;
        end
    end

    mras_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // Sequencer, accumulators and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_rows      <= ROWS_RST;
            r_cols      <= COLS_RST;
            r_p_valid   <= 1'b0;
            r_res_valid <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            // register write restarts the clearing pass
            if (i_cfg.index == mras_pkg::CFG_ROWS) begin
                r_rows <= n_rows;
            end else begin
                r_cols <= n_cols;
            end
            r_state     <= S_CLEAR;
            r_sweep     <= '0;
            r_p_valid   <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            // query accumulation on returning read data
            if (r_p_valid && (r_op == mras_pkg::OP_QUERY)) begin
                r_sum <= r_sum + w_rdata[SUM_W-1:0];
                if (w_rdata < r_min) begin
                    r_min <= w_rdata;
                end
                if (w_rdata > r_max) begin
                    r_max <= w_rdata;
                end
            end

            case (r_state)
                S_CLEAR: begin
                    r_sweep <= r_sweep + AW'(1);
                    if (r_sweep == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_req_acc && (i_req.opcode != mras_pkg::OP_NONE)) begin
                        r_op  <= i_req.opcode;
                        r_val <= i_req.operand_value;
                        r_rhi <= w_rhi;
                        r_clo <= w_clo;
                        r_chi <= w_chi;
                        r_row <= w_rlo;
                        r_col <= w_clo;
                        r_sum <= '0;
                        r_min <= '1;
                        r_max <= '0;
                        if (!w_empty) begin
                            r_state <= S_RUN;
                        end else if (i_req.opcode == mras_pkg::OP_QUERY) begin
                            r_res_sum   <= '0;
                            r_res_min   <= '1;
                            r_res_max   <= '0;
                            r_res_valid <= 1'b1;
                            r_state     <= S_OUT;
                        end
                    end
                end
                S_RUN: begin
                    r_p_valid <= 1'b1;
                    r_p_addr  <= w_raddr;
                    if (r_col == r_chi) begin
                        r_col <= r_clo;
                        if (r_row == r_rhi) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_row <= r_row + ROW_W'(1);
                        end
                    end else begin
                        r_col <= r_col + COL_W'(1);
                    end
                end
                S_DRAIN: begin
                    // last element is written or accumulated here
                    r_p_valid <= 1'b0;
                    r_state   <= (r_op == mras_pkg::OP_QUERY) ? S_LOAD : S_IDLE;
                end
                S_LOAD: begin
                    r_res_sum   <= r_sum;
                    r_res_min   <= r_min[VAL_W-1:0];
                    r_res_max   <= r_max[VAL_W-1:0];
                    r_res_valid <= 1'b1;
                    r_state     <= S_OUT;
                end
                S_OUT: begin
                    if (o_res.ready) begin
                        r_res_valid <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                    r_sweep <= '0;
                end
            endcase
        end
    end

    // Checks
    `MRAS_ASSERT_NEXT(a_cfg_clears, i_clk, i_rst_n, i_cfg.valid && i_cfg.ready,
        r_state == S_CLEAR, "config write did not start clearing")
    `MRAS_ASSERT_SAME(a_walk_bounds, i_clk, i_rst_n, r_state == S_RUN,
        (r_row <= r_rhi) && (r_col <= r_chi) && (r_col >= r_clo), "walk left the rectangle")
    `MRAS_ASSERT_SAME(a_no_write_out, i_clk, i_rst_n, (r_state == S_OUT) || (r_state == S_LOAD),
        !w_we, "memory written while result pending")

endmodule

`default_nettype wire

/* tb/mras_tb_pkg.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// mras_tb_pkg
// Matrix shadow and answer scoreboard for the rectangle add / set / query
// block. Elements are kept exactly, one by one, and each query is summed
// over the clipped rectangle.
// ---------------------------------------------------------------------------
package mras_tb_pkg;
    import mras_pkg::*;

    typedef struct {
        logic [SUM_W-1:0] sum;
        logic [VAL_W-1:0] lo;
        logic [VAL_W-1:0] hi;
    } answer_t;

    class rect_scoreboard;
        longint unsigned elem [MAX_ROWS_DEF][MAX_COLS_DEF];
        int unsigned     rows_used;
        int unsigned     cols_used;
        answer_t         answers [$];
        int unsigned     fail_count;

        function new();
            rows_used  = RESET_ROWS;
            cols_used  = RESET_COLS;
            fail_count = 0;
            clear_matrix();
        endfunction

        function void clear_matrix();
            foreach (elem[r, c]) elem[r][c] = 0;
        endfunction

        // Size registers saturate and always wipe the store
        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            int unsigned v;
            if (idx == CFG_ROWS) begin
                v = data & 'h3F;
                if (v < 1) v = 1;
                if (v > MAX_ROWS_DEF) v = MAX_ROWS_DEF;
                rows_used = v;
            end else begin
                v = data & 'h7FF;
                if (v < 1) v = 1;
                if (v > MAX_COLS_DEF) v = MAX_COLS_DEF;
                cols_used = v;
            end
            clear_matrix();
        endfunction

        // Apply one accepted request to the shadow; queue an answer for a query
        function void note_request(logic [OP_W-1:0] op, logic [ROW_W-1:0] rlo_in,
                                   logic [ROW_W-1:0] rhi_in, logic [COL_W-1:0] clo_in,
                                   logic [COL_W-1:0] chi_in, logic [VAL_W-1:0] v);
            int unsigned     rlo, rhi, clo, chi;
            bit              empty;
            longint unsigned acc_sum, acc_min, acc_max;
            answer_t         a;
            if (op == OP_NONE) return;
            rlo = rlo_in; rhi = rhi_in; clo = clo_in; chi = chi_in;
            if (rlo < 1) rlo = 1;
            if (rhi > rows_used) rhi = rows_used;
            if (clo < 1) clo = 1;
            if (chi > cols_used) chi = cols_used;
            empty   = (rlo > rhi) || (clo > chi);
            acc_sum = 0;
            acc_min = '1;
            acc_max = 0;
            if (!empty) begin
                for (int unsigned r = rlo; r <= rhi; r++) begin
                    for (int unsigned c = clo; c <= chi; c++) begin
                        case (op)
                            OP_ADD:    elem[r-1][c-1] += v;
                            OP_ASSIGN: elem[r-1][c-1] = v;
                            default: begin
                                acc_sum += elem[r-1][c-1];
                                if (elem[r-1][c-1] < acc_min) acc_min = elem[r-1][c-1];
                                if (elem[r-1][c-1] > acc_max) acc_max = elem[r-1][c-1];
                            end
                        endcase
                    end
                end
            end
            if (op != OP_QUERY) return;
            a.sum = acc_sum[SUM_W-1:0];
            a.lo  = empty ? '1 : acc_min[VAL_W-1:0];
            a.hi  = empty ? '0 : acc_max[VAL_W-1:0];
            answers.insert(answers.size(), a);
        endfunction

        function void check_result(logic [SUM_W-1:0] sum, logic [VAL_W-1:0] lo,
                                   logic [VAL_W-1:0] hi);
            answer_t a;
            if (answers.size() == 0) begin
                $display("%0t: unexpected result sum=%0d min=%0d max=%0d", $time, sum, lo, hi);
                fail_count++;
                return;
            end
            a = answers.pop_front();
            if (sum !== a.sum) begin
                $display("%0t: total_sum expected %0d actual %0d", $time, a.sum, sum);
                fail_count++;
            end
            if (lo !== a.lo) begin
                $display("%0t: min_value expected %0d actual %0d", $time, a.lo, lo);
                fail_count++;
            end
            if (hi !== a.hi) begin
                $display("%0t: max_value expected %0d actual %0d", $time, a.hi, hi);
                fail_count++;
            end
        endfunction

        function int pending();
            return answers.size();
        endfunction
    endclass
endpackage

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Drives rectangle add, assign and query requests through several matrix
// sizes, with bursty requests and a stalling result side, and checks every
// query answer against an element-by-element shadow of the matrix.
// ---------------------------------------------------------------------------
module tb_top;
    import mras_pkg::*;
    import mras_tb_pkg::*;

    localparam logic [VAL_W-1:0] VAL_TOP = '1;

    logic i_clk;
    logic i_rst_n;

    mras_req_if req ();
    mras_res_if res ();
    mras_cfg_if cfg ();

    matrix_range_add_set_query u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    rect_scoreboard sb = new();
    int unsigned    burst_left = 0;
    int unsigned    ready_cnt  = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Limit on the whole run
    initial begin
        #50_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // Record accepted requests and check accepted results
    always @(posedge i_clk) begin
        if (i_rst_n && req.valid && req.ready)
            sb.note_request(req.opcode, req.row_lo, req.row_hi, req.col_lo, req.col_hi,
                            req.operand_value);
        if (i_rst_n && res.valid && res.ready)
            sb.check_result(res.total_sum, res.min_value, res.max_value);
    end

    // Result side: calm stretches alternate with random stalls
    always @(negedge i_clk) begin
        ready_cnt <= ready_cnt + 1;
        if ((ready_cnt / 300) % 3 == 0)
            res.ready <= 1'b1;
        else
            res.ready <= ($urandom_range(0, 2) != 0);
    end

    task automatic send_req(logic [OP_W-1:0] op, logic [ROW_W-1:0] rlo, logic [ROW_W-1:0] rhi,
                            logic [COL_W-1:0] clo, logic [COL_W-1:0] chi,
                            logic [VAL_W-1:0] v);
        int unsigned gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                req.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        req.opcode        <= op;
        req.row_lo        <= rlo;
        req.row_hi        <= rhi;
        req.col_lo        <= clo;
        req.col_hi        <= chi;
        req.operand_value <= v;
        req.valid         <= 1'b1;
        do @(posedge i_clk); while (!req.ready);
    endtask

    // Drop the request and let every answer and any running walk finish
    task automatic drain();
        @(negedge i_clk);
        req.valid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (sb.rows_used * sb.cols_used + 8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg.index <= idx;
        cfg.data  <= data;
        cfg.valid <= 1'b1;
        do @(posedge i_clk); while (!cfg.ready);
        sb.write_register(idx, data);
        @(negedge i_clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return VAL_TOP;
            1, 2:    return VAL_W'($urandom());
            default: return VAL_W'($urandom_range(0, 1000));
        endcase
    endfunction

    // Mostly well-formed rectangles inside the matrix; with noise, raw fields
    task automatic random_requests(int unsigned n, bit noise, int unsigned rspan,
                                   int unsigned cspan, int unsigned settle_at);
        logic [OP_W-1:0]  op;
        logic [ROW_W-1:0] rlo, rhi;
        logic [COL_W-1:0] clo, chi;
        int unsigned      k;
        for (int i = 0; i < n; i++) begin
            if (i == settle_at) drain();
            k = $urandom_range(0, 19);
            op = (k < 7) ? OP_ADD : (k < 11) ? OP_ASSIGN : (k < 19) ? OP_QUERY : OP_NONE;
            if (noise && $urandom_range(0, 4) == 0) begin
                rlo = ROW_W'($urandom()); rhi = ROW_W'($urandom());
                clo = COL_W'($urandom()); chi = COL_W'($urandom());
            end else begin
                rlo = ROW_W'($urandom_range(1, sb.rows_used));
                rhi = rlo + ROW_W'($urandom_range(0, rspan));
                if (rhi > sb.rows_used) rhi = ROW_W'(sb.rows_used);
                clo = COL_W'($urandom_range(1, sb.cols_used));
                chi = clo + COL_W'($urandom_range(0, cspan));
                if (chi > sb.cols_used) chi = COL_W'(sb.cols_used);
            end
            send_req(op, rlo, rhi, clo, chi, pick_value());
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        req.valid         = 1'b0;
        req.opcode        = OP_NONE;
        req.row_lo        = '0;
        req.row_hi        = '0;
        req.col_lo        = '0;
        req.col_hi        = '0;
        req.operand_value = '0;
        res.ready         = 1'b0;
        cfg.valid         = 1'b0;
        cfg.index         = CFG_ROWS;
        cfg.data          = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed, at the reset size of 32 x 1024
        send_req(OP_QUERY, 1, 32, 1, 1024, 0);
        send_req(OP_ADD, 1, 1, 1, 1, VAL_TOP);
        send_req(OP_ADD, 1, 1, 1, 2, VAL_TOP);
        send_req(OP_QUERY, 1, 1, 1, 2, 0);
        send_req(OP_ASSIGN, 2, 3, 5, 9, 0);
        send_req(OP_ASSIGN, 2, 3, 4, 6, 12345);
        send_req(OP_QUERY, 1, 3, 1, 10, VAL_TOP);
        // rectangle clipped on three sides
        send_req(OP_ADD, 0, 63, 1020, 2047, 7);
        send_req(OP_QUERY, 0, 63, 1000, 2047, 0);
        // empty rectangles
        send_req(OP_ADD, 5, 4, 1, 1, 9);
        send_req(OP_ASSIGN, 1, 1, 9, 3, 9);
        send_req(OP_QUERY, 5, 4, 1, 1, 0);
        send_req(OP_QUERY, 1, 1, 9, 3, 0);
        send_req(OP_QUERY, 33, 63, 1, 4, 0);
        send_req(OP_NONE, 1, 32, 1, 1024, 5);
        // element pushed past 2^31 - 1
        send_req(OP_ASSIGN, 32, 32, 1024, 1024, VAL_TOP);
        send_req(OP_ADD, 32, 32, 1024, 1024, 1);
        send_req(OP_QUERY, 32, 32, 1023, 1024, 0);
        send_req(OP_ADD, 1, 32, 1, 1024, 3);
        send_req(OP_QUERY, 1, 32, 1, 1024, 0);
        drain();

        // Smallest matrix: 1 x 1
        write_reg(CFG_ROWS, 0);
        write_reg(CFG_COLS, 0);
        random_requests(40, 1'b1, 1, 1, 1000);
        drain();

        // 5 x 13, row data with high bits set; a full settle midway
        write_reg(CFG_ROWS, 11'h7C5);
        write_reg(CFG_COLS, 13);
        random_requests(90, 1'b1, 4, 12, 45);
        drain();

        // Register values above range saturate back to 32 x 1024
        write_reg(CFG_ROWS, 40);
        write_reg(CFG_COLS, 11'h7FF);
        random_requests(50, 1'b0, 1, 15, 1000);
        drain();

        write_reg(CFG_ROWS, 3);
        write_reg(CFG_COLS, 37);
        random_requests(90, 1'b1, 2, 36, 1000);
        drain();

        if (sb.fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
